[hdl/bmpfb_pkg.sv]
// bmpfb_pkg: shared types and constants of the bmp24 centred framebuffer blit core
// request and response payload structs, header layout, queue sizing
// no dependencies
`timescale 1ns / 1ps

package bmpfb_pkg;

   localparam int SCREEN_WIDTH_DEF  = 800;
   localparam int SCREEN_HEIGHT_DEF = 480;

   // header layout, fixed by the file format
   localparam int HEADER_BYTES = 54;
   localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
   localparam int WIDTH_LO     = 18;
   localparam int HEIGHT_LO    = 22;

   // screen coordinates up to 4095 fit in twelve bits
   localparam int COORD_W     = 12;
   localparam int SCR_DIM_W   = 13;
   localparam int ADDR_W      = 19;
   localparam int PIXEL_W     = 24;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  fb_address;
      logic [PIXEL_W-1:0] pixel_value;
      logic               size_error;
      logic               last_pixel;
   } rsp_type;

   // classified request handed from parser to address stage
   typedef struct packed {
      logic               is_error;
      logic               last;
      logic [PIXEL_W-1:0] pixel;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } evt_type;

   localparam int EVT_W = $bits(evt_type);
   localparam int RSP_W = $bits(rsp_type);

endpackage

[hdl/bmpfb_fifo.sv]
// bmpfb_fifo: small register queue with full/empty flags
// depends on nothing but its parameters
`timescale 1ns / 1ps

module bmpfb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/bmpfb_front.sv]
// bmpfb_front: byte parser, reads the header, skips row padding, gathers pixels
// and tracks the screen position; emits pixel and size-error events
// depends on bmpfb_pkg
`timescale 1ns / 1ps

module bmpfb_front
   import bmpfb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req_data,
   output logic    evt_push,
   output evt_type evt_data
);

   localparam int CW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
   localparam int WW = $clog2(SCREEN_WIDTH + 1);
   localparam int RW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
   localparam int HW = $clog2(SCREEN_HEIGHT + 1);
   localparam int HALF_W = SCREEN_WIDTH / 2;
   localparam int HALF_H = SCREEN_HEIGHT / 2;

   logic [HDR_CNT_W-1:0] hdr_cnt_ff, hdr_cnt_in, s_hdr_cnt;
   logic                 hdr_done_ff, hdr_done_in, s_hdr_done;
   logic [31:0]          width_ff, width_in, s_width;
   logic [31:0]          height_ff, height_in, s_height;
   logic [CW-1:0]        col_cnt_ff, col_cnt_in, s_col_cnt;
   logic [HW-1:0]        row_cnt_ff, row_cnt_in, s_row_cnt;
   logic [1:0]           phase_ff, phase_in, s_phase;
   logic [1:0]           pad_ff, pad_in, s_pad;
   logic                 rejected_ff, rejected_in, s_rejected;
   logic [7:0]           blue_ff, blue_in;
   logic [7:0]           green_ff, green_in;
   logic [CW-1:0]        col0_ff, col0_in;
   logic [CW-1:0]        scr_col_ff, scr_col_in;
   logic [RW-1:0]        scr_row_ff, scr_row_in;

   logic [7:0]     b;
   logic [1:0]     sel;
   logic [WW-1:0]  w_n;
   logic [HW-1:0]  h_n;
   logic           bad_size;
   logic           row_end;
   logic           ev_valid;
   evt_type        ev;

   assign b = req_data.data_byte;

   always_comb begin
      // a file_start byte sees cleared parser state
      s_hdr_cnt  = req_data.file_start ? '0 : hdr_cnt_ff;
      s_hdr_done = req_data.file_start ? 1'b0 : hdr_done_ff;
      s_width    = req_data.file_start ? '0 : width_ff;
      s_height   = req_data.file_start ? '0 : height_ff;
      s_col_cnt  = req_data.file_start ? '0 : col_cnt_ff;
      s_row_cnt  = req_data.file_start ? '0 : row_cnt_ff;
      s_phase    = req_data.file_start ? '0 : phase_ff;
      s_pad      = req_data.file_start ? '0 : pad_ff;
      s_rejected = req_data.file_start ? 1'b0 : rejected_ff;

      hdr_cnt_in  = s_hdr_cnt;
      hdr_done_in = s_hdr_done;
      width_in    = s_width;
      height_in   = s_height;
      col_cnt_in  = s_col_cnt;
      row_cnt_in  = s_row_cnt;
      phase_in    = s_phase;
      pad_in      = s_pad;
      rejected_in = s_rejected;
      blue_in     = blue_ff;
      green_in    = green_ff;
      col0_in     = col0_ff;
      scr_col_in  = scr_col_ff;
      scr_row_in  = scr_row_ff;

      sel      = '0;
      bad_size = 1'b0;
      row_end  = 1'b0;
      ev_valid = 1'b0;
      ev       = '0;

      w_n = s_width[WW-1:0];
      h_n = s_height[HW-1:0];

      if (!s_hdr_done) begin
         if (s_hdr_cnt >= HDR_CNT_W'(WIDTH_LO) && s_hdr_cnt < HDR_CNT_W'(WIDTH_LO + 4)) begin
            sel = 2'(s_hdr_cnt - HDR_CNT_W'(WIDTH_LO));
            width_in[{sel, 3'b000} +: 8] = b;
         end else if (s_hdr_cnt >= HDR_CNT_W'(HEIGHT_LO) &&
                      s_hdr_cnt < HDR_CNT_W'(HEIGHT_LO + 4)) begin
            sel = 2'(s_hdr_cnt - HDR_CNT_W'(HEIGHT_LO));
            height_in[{sel, 3'b000} +: 8] = b;
         end
         hdr_cnt_in = s_hdr_cnt + HDR_CNT_W'(1);
         if (s_hdr_cnt == HDR_CNT_W'(HEADER_BYTES - 1)) begin
            hdr_done_in = 1'b1;
            bad_size = (width_in == '0) || (height_in == '0) ||
                       (width_in > 32'(SCREEN_WIDTH)) || (height_in > 32'(SCREEN_HEIGHT));
            w_n = width_in[WW-1:0];
            h_n = height_in[HW-1:0];
            // left column and bottom screen row of the centred picture
            col0_in    = CW'(WW'(HALF_W) - (w_n >> 1));
            scr_col_in = CW'(WW'(HALF_W) - (w_n >> 1));
            scr_row_in = RW'(HW'(HALF_H) + h_n - (h_n >> 1) - HW'(1));
            if (bad_size) begin
               rejected_in = 1'b1;
               ev_valid    = 1'b1;
               ev.is_error = 1'b1;
            end
         end
      end else if (!s_rejected && s_row_cnt < h_n) begin
         if (s_pad != 2'd0) begin
            pad_in = s_pad - 2'd1;
         end else begin
            unique case (s_phase)
               2'd0: begin
                  blue_in  = b;
                  phase_in = 2'd1;
               end
               2'd1: begin
                  green_in = b;
                  phase_in = 2'd2;
               end
               default: begin
                  phase_in = 2'd0;
                  row_end  = (WW'(s_col_cnt) + WW'(1) == w_n);
                  ev_valid = 1'b1;
                  ev.pixel = {b, green_ff, blue_ff};
                  ev.row   = COORD_W'(scr_row_ff);
                  ev.col   = COORD_W'(scr_col_ff);
                  ev.last  = row_end && (s_row_cnt + HW'(1) == h_n);
                  if (row_end) begin
                     col_cnt_in = '0;
                     row_cnt_in = s_row_cnt + HW'(1);
                     pad_in     = w_n[1:0];
                     scr_col_in = col0_ff;
                     scr_row_in = scr_row_ff - RW'(1);
                  end else begin
                     col_cnt_in = s_col_cnt + CW'(1);
                     scr_col_in = scr_col_ff + CW'(1);
                  end
               end
            endcase
         end
      end
   end

   assign evt_push = accept && ev_valid;
   assign evt_data = ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff  <= '0;
         hdr_done_ff <= 1'b0;
         width_ff    <= '0;
         height_ff   <= '0;
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         phase_ff    <= '0;
         pad_ff      <= '0;
         rejected_ff <= 1'b0;
      end else if (accept) begin
         hdr_cnt_ff  <= hdr_cnt_in;
         hdr_done_ff <= hdr_done_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_cnt_ff  <= col_cnt_in;
         row_cnt_ff  <= row_cnt_in;
         phase_ff    <= phase_in;
         pad_ff      <= pad_in;
         rejected_ff <= rejected_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         blue_ff    <= blue_in;
         green_ff   <= green_in;
         col0_ff    <= col0_in;
         scr_col_ff <= scr_col_in;
         scr_row_ff <= scr_row_in;
      end
   end

endmodule

[hdl/bmpfb_back.sv]
// bmpfb_back: turns queued events into framebuffer writes, row * width + column,
// and holds them in the response queue
// depends on bmpfb_pkg, bmpfb_fifo
`timescale 1ns / 1ps

module bmpfb_back
   import bmpfb_pkg::*;
#(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    evt_empty,
   input  evt_type evt_data,
   output logic    evt_pop,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp_data
);

   localparam int PW = COORD_W + SCR_DIM_W;

   logic [PW-1:0]    addr_wide;
   rsp_type          rsp_next;
   logic             out_full;
   logic [RSP_W-1:0] out_bits;

   assign addr_wide = PW'(evt_data.row) * PW'(SCREEN_WIDTH) + PW'(evt_data.col);

   always_comb begin
      rsp_next.fb_address  = addr_wide[ADDR_W-1:0];
      rsp_next.pixel_value = evt_data.pixel;
      rsp_next.size_error  = evt_data.is_error;
      rsp_next.last_pixel  = evt_data.last;
   end

   assign evt_pop  = !evt_empty && !out_full;
   assign rsp_data = rsp_type'(out_bits);

   bmpfb_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_out_q (
      .clock    (clock),
      .reset    (reset),
      .push     (evt_pop),
      .push_data(rsp_next),
      .full     (out_full),
      .pop      (pop),
      .pop_data (out_bits),
      .empty    (empty)
   );

endmodule

[hdl/bmp24_centered_framebuffer_blit_core.sv]
// bmp24 centred framebuffer blit: one file byte per cycle in while full is low, pixel writes out
// throughput: one request per cycle while full is low; at most one write per three pixel bytes
// path of a write from its last byte to the response side: parser, event queue,
// address multiply into the response queue; a full response queue holds it back
// reset: synchronous, clears parser and both queues; parsing starts at header byte 0
// depends on bmpfb_pkg, bmpfb_front, bmpfb_back, bmpfb_fifo
`timescale 1ns / 1ps

module bmp24_centered_framebuffer_blit_core
   import bmpfb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic             accept;
   logic             evt_push;
   evt_type          evt_in;
   logic             evt_pop;
   logic             evt_empty;
   logic [EVT_W-1:0] evt_bits;

   assign accept = push && !full;

   bmpfb_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req_data(req_data),
      .evt_push(evt_push),
      .evt_data(evt_in)
   );

   // decoupling queue between parser and address stage
   bmpfb_fifo #(
      .WIDTH(EVT_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_evt_q (
      .clock    (clock),
      .reset    (reset),
      .push     (evt_push),
      .push_data(evt_in),
      .full     (full),
      .pop      (evt_pop),
      .pop_data (evt_bits),
      .empty    (evt_empty)
   );

   bmpfb_back #(
      .SCREEN_WIDTH(SCREEN_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .evt_empty(evt_empty),
      .evt_data (evt_type'(evt_bits)),
      .evt_pop  (evt_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule
